FILE: design/mau_pkg.sv
// Package with the payload types, job type and codes of the modular arithmetic unit.
package mau_pkg;

   // Width of every data field on the ports.
   localparam int DATA_BITS = 64;

   // Request codes.
   localparam logic [2:0] OP_ADD_MOD     = 3'd0;
   localparam logic [2:0] OP_WIDE_MUL    = 3'd1;
   localparam logic [2:0] OP_MUL_MOD     = 3'd2;
   localparam logic [2:0] OP_DIVIDE      = 3'd3;
   localparam logic [2:0] OP_DIVIDE_MOD  = 3'd4;
   localparam logic [2:0] OP_NEGATE_MOD  = 3'd5;

   // Status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [DATA_BITS-1:0] operand_a;
      logic [DATA_BITS-1:0] operand_b;
      logic [DATA_BITS-1:0] dividend_high;
      logic [DATA_BITS-1:0] dividend_low;
      logic [DATA_BITS-1:0] divisor;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] result_low;
      logic [DATA_BITS-1:0] result_high;
      logic [DATA_BITS-1:0] remainder_out;
      logic [1:0]           status;
   } rsp_payload_type;

   // A classified job handed from the front end to the divider back end.
   typedef struct packed {
      logic [2:0]           op;
      logic [1:0]           status;
      logic [DATA_BITS-1:0] div_hi;
      logic [DATA_BITS-1:0] div_lo;
      logic [DATA_BITS-1:0] divisor;
      logic [DATA_BITS-1:0] modulus;
   } job_type;

endpackage

FILE: design/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: front end, job queue and divider back end.
//
// Request beats arrive on req_valid/req_ready/req_data and carry the operation code and
// all operands; each request gives exactly one response beat on rsp_valid/rsp_ready/
// rsp_data, in request order. The modulus is written through csr_write_enable and
// csr_write_data; the user must write it only while the unit is idle, as the block does not
// enforce this, and it is sampled per request as it enters. Requests pass through two front-end
// stages for the split multiply and classification, the two-entry job queue, a
// pipelined restoring divider of 2*WORD_BITS stages, a second one of WORD_BITS stages
// for the quotient reduction, and the output register. One request is taken per cycle
// while the receiver keeps up, set by the one-quotient-bit-per-stage divider pipeline.
// When the receiver stalls, the divider pipeline holds as a whole; the two-entry queue
// and the two front-end stages keep taking requests until they are full as well.
// Synchronous reset empties every stage and the queue and sets the modulus to one.
module modular_arithmetic_unit #(
   parameter int WORD_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mau_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mau_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_write_enable,
   input  logic [63:0]              csr_write_data
);

   logic [WORD_BITS-1:0] modulus_ff;
   logic                 fj_valid, fj_ready, bj_valid, bj_ready;
   mau_pkg::job_type     fj_data, bj_data;

   // Modulus register.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WORD_BITS'(1);
      end else if (csr_write_enable) begin
         modulus_ff <= csr_write_data[WORD_BITS-1:0];
      end
   end

   mau_front #(.W(WORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .modulus   (modulus_ff),
      .job_valid (fj_valid),
      .job_ready (fj_ready),
      .job_data  (fj_data)
   );

   mau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_data  (fj_data),
      .pop_valid  (bj_valid),
      .pop_ready  (bj_ready),
      .pop_data   (bj_data)
   );

   mau_back #(.W(WORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bj_valid),
      .job_ready (bj_ready),
      .job_data  (bj_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // No job leaves the queue while a response beat is held.
   a_no_pop_in_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(bj_valid && bj_ready))
      else $error("job taken from queue while the output is stalled");

   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Error responses carry zero results.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != mau_pkg::STATUS_OK) |->
      (rsp_data.result_low == '0 && rsp_data.result_high == '0 &&
       rsp_data.remainder_out == '0))
      else $error("error response with nonzero result fields");

endmodule

FILE: design/mau_front.sv
// Front end: accepts request beats, forms the product and classifies each job.
module mau_front #(
   parameter int W = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mau_pkg::req_payload_type req_data,
   input  logic [W-1:0]           modulus,
   output logic                   job_valid,
   input  logic                   job_ready,
   output mau_pkg::job_type       job_data
);

   localparam int H  = (W + 1) / 2;
   localparam int G  = W - H;
   localparam int PW = 2 * W;

   logic            f0_v_ff;
   logic [2:0]      f0_op_ff;
   logic [W-1:0]    f0_a_ff, f0_b_ff, f0_dh_ff, f0_dl_ff, f0_dv_ff, f0_md_ff;
   logic [2*H-1:0]  ll_ff, ll_in;
   logic [W-1:0]    lh_ff, lh_in, hl_ff, hl_in;
   logic [2*G-1:0]  hh_ff, hh_in;
   logic            f1_v_ff;
   mau_pkg::job_type f1_job_ff, job_in;
   logic            en0, en1;
   logic [H-1:0]    al, bl;
   logic [G-1:0]    ah, bh;
   logic [PW-1:0]   prod;
   logic [W:0]      sum;

   // Each stage loads when it is empty or its content moves on.
   assign en1       = !f1_v_ff || job_ready;
   assign en0       = !f0_v_ff || en1;
   assign req_ready = en0;

   // Partial products of the operand halves.
   assign al    = req_data.operand_a[H-1:0];
   assign ah    = req_data.operand_a[W-1:H];
   assign bl    = req_data.operand_b[H-1:0];
   assign bh    = req_data.operand_b[W-1:H];
   assign ll_in = {{H{1'b0}}, al} * {{H{1'b0}}, bl};
   assign lh_in = {{G{1'b0}}, al} * {{H{1'b0}}, bh};
   assign hl_in = {{H{1'b0}}, ah} * {{G{1'b0}}, bl};
   assign hh_in = {{G{1'b0}}, ah} * {{G{1'b0}}, bh};

   // Stage 0 valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         f0_v_ff <= 1'b0;
      end else if (en0) begin
         f0_v_ff <= req_valid;
      end
   end

   // Stage 0 payload.
   always_ff @(posedge clock) begin
      if (en0 && req_valid) begin
         f0_op_ff <= req_data.req_type;
         f0_a_ff  <= req_data.operand_a[W-1:0];
         f0_b_ff  <= req_data.operand_b[W-1:0];
         f0_dh_ff <= req_data.dividend_high[W-1:0];
         f0_dl_ff <= req_data.dividend_low[W-1:0];
         f0_dv_ff <= req_data.divisor[W-1:0];
         f0_md_ff <= modulus;
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         hl_ff    <= hl_in;
         hh_ff    <= hh_in;
      end
   end

   // Sum the partial products and the carry-extended sum.
   assign prod = {hh_ff, ll_ff} + (PW'(lh_ff) << H) + (PW'(hl_ff) << H);
   assign sum  = {1'b0, f0_a_ff} + {1'b0, f0_b_ff};

   // Classify the job and pick the dividend and divisor.
   always_comb begin
      job_in         = '0;
      job_in.op      = f0_op_ff;
      job_in.status  = mau_pkg::STATUS_OK;
      job_in.modulus = 64'(f0_md_ff);
      case (f0_op_ff)
         mau_pkg::OP_ADD_MOD: begin
            if (f0_md_ff == '0) begin
               job_in.status = mau_pkg::STATUS_DIV_ZERO;
            end
            job_in.div_hi  = 64'(sum[W]);
            job_in.div_lo  = 64'(sum[W-1:0]);
            job_in.divisor = 64'(f0_md_ff);
         end
         mau_pkg::OP_WIDE_MUL, mau_pkg::OP_MUL_MOD: begin
            if (f0_op_ff == mau_pkg::OP_MUL_MOD && f0_md_ff == '0) begin
               job_in.status = mau_pkg::STATUS_DIV_ZERO;
            end
            job_in.div_hi  = 64'(prod[PW-1:W]);
            job_in.div_lo  = 64'(prod[W-1:0]);
            job_in.divisor = 64'(f0_md_ff);
         end
         mau_pkg::OP_DIVIDE, mau_pkg::OP_DIVIDE_MOD: begin
            if (f0_dv_ff == '0 ||
                (f0_op_ff == mau_pkg::OP_DIVIDE_MOD && f0_md_ff == '0)) begin
               job_in.status = mau_pkg::STATUS_DIV_ZERO;
            end else if (f0_dh_ff >= f0_dv_ff) begin
               job_in.status = mau_pkg::STATUS_OVERFLOW;
            end
            job_in.div_hi  = 64'(f0_dh_ff);
            job_in.div_lo  = 64'(f0_dl_ff);
            job_in.divisor = 64'(f0_dv_ff);
         end
         mau_pkg::OP_NEGATE_MOD: begin
            if (f0_md_ff == '0) begin
               job_in.status = mau_pkg::STATUS_DIV_ZERO;
            end
            job_in.div_lo  = 64'(f0_a_ff);
            job_in.divisor = 64'(f0_md_ff);
         end
         default: begin
            job_in.divisor = 64'(f0_md_ff);
         end
      endcase
   end

   // Stage 1 valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (en1) begin
         f1_v_ff <= f0_v_ff;
      end
   end

   // Stage 1 payload.
   always_ff @(posedge clock) begin
      if (en1 && f0_v_ff) begin
         f1_job_ff <= job_in;
      end
   end

   assign job_valid = f1_v_ff;
   assign job_data  = f1_job_ff;

endmodule

FILE: design/mau_queue.sv
// Two-entry job queue between the front end and the back end.
module mau_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  mau_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output mau_pkg::job_type pop_data
);

   localparam int DEPTH = 2;
   localparam int CW    = $clog2(DEPTH + 1);

   mau_pkg::job_type entries_ff [0:DEPTH-1];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entries_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/mau_back.sv
// Back end: pipelined restoring dividers and the output register.
module mau_back #(
   parameter int W = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  mau_pkg::job_type        job_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mau_pkg::rsp_payload_type rsp_data
);

   localparam int PW = 2 * W;
   localparam int N1 = 2 * W;
   localparam int N2 = W;

   // First divider: double word by word, one quotient bit per stage.
   logic          d1_v_ff   [0:N1];
   logic [W-1:0]  d1_rem_ff [0:N1];
   logic [W-1:0]  d1_quo_ff [0:N1];
   logic [PW-1:0] d1_num_ff [0:N1];
   logic [W-1:0]  d1_dvs_ff [0:N1];
   logic [W-1:0]  d1_md_ff  [0:N1];
   logic [2:0]    d1_op_ff  [0:N1];
   logic [1:0]    d1_st_ff  [0:N1];

   // Second divider: quotient reduced by the modulus.
   logic          d2_v_ff   [0:N2];
   logic [W-1:0]  d2_rem_ff [0:N2];
   logic [W-1:0]  d2_num_ff [0:N2];
   logic [W-1:0]  d2_md_ff  [0:N2];
   logic [2:0]    d2_op_ff  [0:N2];
   logic [1:0]    d2_st_ff  [0:N2];
   logic [W-1:0]  d2_lo_ff  [0:N2];
   logic [W-1:0]  d2_hi_ff  [0:N2];
   logic [W-1:0]  d2_rr_ff  [0:N2];

   logic                     rsp_v_ff;
   mau_pkg::rsp_payload_type rsp_data_ff, rsp_in;
   logic                     stall;
   logic [W-1:0]             mid_lo, mid_hi, mid_rr;
   logic [W-1:0]             r1, q1;

   // The whole back end holds while a finished beat waits to be taken.
   assign stall     = rsp_v_ff && !rsp_ready;
   assign job_ready = !stall;

   // First divider entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff[0] <= 1'b0;
      end else if (!stall) begin
         d1_v_ff[0] <= job_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         d1_rem_ff[0] <= '0;
         d1_quo_ff[0] <= '0;
         d1_num_ff[0] <= {job_data.div_hi[W-1:0], job_data.div_lo[W-1:0]};
         d1_dvs_ff[0] <= job_data.divisor[W-1:0];
         d1_md_ff[0]  <= job_data.modulus[W-1:0];
         d1_op_ff[0]  <= job_data.op;
         d1_st_ff[0]  <= job_data.status;
      end
   end

   // First divider steps; the dividend rotates so that it is whole again at the end.
   for (genvar k = 1; k <= N1; k++) begin : g_div1
      logic [W-1:0] shifted, rem_in;
      logic         take;

      assign shifted = {d1_rem_ff[k-1][W-2:0], d1_num_ff[k-1][PW-1]};
      assign take    = d1_rem_ff[k-1][W-1] || (shifted >= d1_dvs_ff[k-1]);
      assign rem_in  = take ? shifted - d1_dvs_ff[k-1] : shifted;

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_v_ff[k] <= 1'b0;
         end else if (!stall) begin
            d1_v_ff[k] <= d1_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (!stall) begin
            d1_rem_ff[k] <= rem_in;
            d1_quo_ff[k] <= {d1_quo_ff[k-1][W-2:0], take};
            d1_num_ff[k] <= {d1_num_ff[k-1][PW-2:0], d1_num_ff[k-1][PW-1]};
            d1_dvs_ff[k] <= d1_dvs_ff[k-1];
            d1_md_ff[k]  <= d1_md_ff[k-1];
            d1_op_ff[k]  <= d1_op_ff[k-1];
            d1_st_ff[k]  <= d1_st_ff[k-1];
         end
      end
   end

   // Result fields after the first division.
   assign r1 = d1_rem_ff[N1];
   assign q1 = d1_quo_ff[N1];

   always_comb begin
      mid_lo = '0;
      mid_hi = '0;
      mid_rr = '0;
      if (d1_st_ff[N1] == mau_pkg::STATUS_OK) begin
         case (d1_op_ff[N1])
            mau_pkg::OP_ADD_MOD, mau_pkg::OP_MUL_MOD: begin
               mid_lo = r1;
            end
            mau_pkg::OP_WIDE_MUL: begin
               mid_lo = d1_num_ff[N1][W-1:0];
               mid_hi = d1_num_ff[N1][PW-1:W];
            end
            mau_pkg::OP_DIVIDE: begin
               mid_lo = q1;
               mid_rr = r1;
            end
            mau_pkg::OP_DIVIDE_MOD: begin
               mid_lo = q1;
            end
            mau_pkg::OP_NEGATE_MOD: begin
               mid_lo = (r1 == '0) ? '0 : d1_md_ff[N1] - r1;
            end
            default: begin
               mid_lo = '0;
            end
         endcase
      end
   end

   // Second divider entry stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff[0] <= 1'b0;
      end else if (!stall) begin
         d2_v_ff[0] <= d1_v_ff[N1];
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         d2_rem_ff[0] <= '0;
         d2_num_ff[0] <= q1;
         d2_md_ff[0]  <= d1_md_ff[N1];
         d2_op_ff[0]  <= d1_op_ff[N1];
         d2_st_ff[0]  <= d1_st_ff[N1];
         d2_lo_ff[0]  <= mid_lo;
         d2_hi_ff[0]  <= mid_hi;
         d2_rr_ff[0]  <= mid_rr;
      end
   end

   // Second divider steps: only the remainder is kept.
   for (genvar k = 1; k <= N2; k++) begin : g_div2
      logic [W-1:0] shifted, rem_in;
      logic         take;

      assign shifted = {d2_rem_ff[k-1][W-2:0], d2_num_ff[k-1][W-1]};
      assign take    = d2_rem_ff[k-1][W-1] || (shifted >= d2_md_ff[k-1]);
      assign rem_in  = take ? shifted - d2_md_ff[k-1] : shifted;

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_v_ff[k] <= 1'b0;
         end else if (!stall) begin
            d2_v_ff[k] <= d2_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (!stall) begin
            d2_rem_ff[k] <= rem_in;
            d2_num_ff[k] <= {d2_num_ff[k-1][W-2:0], 1'b0};
            d2_md_ff[k]  <= d2_md_ff[k-1];
            d2_op_ff[k]  <= d2_op_ff[k-1];
            d2_st_ff[k]  <= d2_st_ff[k-1];
            d2_lo_ff[k]  <= d2_lo_ff[k-1];
            d2_hi_ff[k]  <= d2_hi_ff[k-1];
            d2_rr_ff[k]  <= d2_rr_ff[k-1];
         end
      end
   end

   // Final result: the reduced quotient replaces the quotient where asked for.
   always_comb begin
      rsp_in.result_low    = 64'(d2_lo_ff[N2]);
      rsp_in.result_high   = 64'(d2_hi_ff[N2]);
      rsp_in.remainder_out = 64'(d2_rr_ff[N2]);
      rsp_in.status        = d2_st_ff[N2];
      if (d2_op_ff[N2] == mau_pkg::OP_DIVIDE_MOD && d2_st_ff[N2] == mau_pkg::STATUS_OK) begin
         rsp_in.result_low = 64'(d2_rem_ff[N2]);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (!stall) begin
         rsp_v_ff <= d2_v_ff[N2];
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the modular arithmetic unit with its own arithmetic predictor.
module tb;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   mau_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   mau_pkg::rsp_payload_type rsp_data;
   logic                     csr_write_enable;
   logic [63:0]              csr_write_data;

   // Extra wait that drain adds after the last expected response has arrived.
   localparam int PIPE_CYCLES = 197;

   // Modulus as the predictor sees it.
   logic [63:0] modulus_now;

   // Requests waiting to be driven, and results waiting to arrive.
   mau_pkg::req_payload_type pending_reqs[$];
   mau_pkg::rsp_payload_type expected_rsps[$];

   int error_count   = 0;
   int beats_sent    = 0;
   int beats_issued  = 0;
   int beats_checked = 0;
   int rsp_seen      = 0;
   int req_wait;
   int rsp_wait;
   int rsp_gap;

   modular_arithmetic_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Clock with a period of 12 time units.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Predict the result of one request under the current modulus.
   function automatic mau_pkg::rsp_payload_type predict_result(mau_pkg::req_payload_type rq,
                                                               logic [63:0] md);
      mau_pkg::rsp_payload_type res;
      logic [127:0]             wide;
      logic [127:0]             quot;
      logic [64:0]              sum;
      res = '0;
      case (rq.req_type)
         mau_pkg::OP_ADD_MOD: begin
            if (md == 0) res.status = mau_pkg::STATUS_DIV_ZERO;
            else begin
               sum = {1'b0, rq.operand_a} + {1'b0, rq.operand_b};
               res.result_low = 64'(sum % {1'b0, md});
            end
         end
         mau_pkg::OP_WIDE_MUL: begin
            wide = {64'd0, rq.operand_a} * {64'd0, rq.operand_b};
            res.result_low  = wide[63:0];
            res.result_high = wide[127:64];
         end
         mau_pkg::OP_MUL_MOD: begin
            if (md == 0) res.status = mau_pkg::STATUS_DIV_ZERO;
            else begin
               wide = {64'd0, rq.operand_a} * {64'd0, rq.operand_b};
               res.result_low = 64'(wide % {64'd0, md});
            end
         end
         mau_pkg::OP_DIVIDE, mau_pkg::OP_DIVIDE_MOD: begin
            if (rq.divisor == 0 || (rq.req_type == mau_pkg::OP_DIVIDE_MOD && md == 0))
               res.status = mau_pkg::STATUS_DIV_ZERO;
            else if (rq.dividend_high >= rq.divisor) res.status = mau_pkg::STATUS_OVERFLOW;
            else begin
               wide = {rq.dividend_high, rq.dividend_low};
               quot = wide / {64'd0, rq.divisor};
               if (rq.req_type == mau_pkg::OP_DIVIDE) begin
                  res.result_low    = quot[63:0];
                  res.remainder_out = 64'(wide % {64'd0, rq.divisor});
               end else begin
                  res.result_low = quot[63:0] % md;
               end
            end
         end
         mau_pkg::OP_NEGATE_MOD: begin
            if (md == 0) res.status = mau_pkg::STATUS_DIV_ZERO;
            else if (rq.operand_a % md == 0) res.result_low = '0;
            else res.result_low = md - rq.operand_a % md;
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   // Print one mismatch line and count it.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH beat %0d %s: got %h expected %h", beats_checked, what, got, want);
      error_count++;
   endtask

   // Random 64-bit word, often near the edges.
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'($urandom_range(0, 15));
         3: return '1 - 64'($urandom_range(0, 15));
         4: return 64'($urandom) >> $urandom_range(0, 31);
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   function automatic mau_pkg::req_payload_type rand_req();
      mau_pkg::req_payload_type rq;
      rq.req_type      = 3'($urandom_range(0, 7));
      rq.operand_a     = rand_word();
      rq.operand_b     = rand_word();
      rq.divisor       = rand_word();
      rq.dividend_low  = rand_word();
      // Mostly keep the high word below the divisor so the quotient fits.
      if ($urandom_range(0, 9) < 8 && rq.divisor != 0)
         rq.dividend_high = {$urandom, $urandom} % rq.divisor;
      else
         rq.dividend_high = rand_word();
      return rq;
   endfunction

   function automatic mau_pkg::req_payload_type make_req(logic [2:0] op, logic [63:0] a,
                                                         logic [63:0] b, logic [63:0] dh,
                                                         logic [63:0] dl, logic [63:0] dv);
      mau_pkg::req_payload_type rq;
      rq.req_type = op; rq.operand_a = a; rq.operand_b = b;
      rq.dividend_high = dh; rq.dividend_low = dl; rq.divisor = dv;
      return rq;
   endfunction

   // Request sampler: predicts each beat as it is taken.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_rsps.push_back(predict_result(req_data, modulus_now));
         beats_sent++;
      end
   end

   // Request driver: one beat per queue entry, with a random gap before the next.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_wait  <= 0;
      end else if (req_valid && beats_sent != beats_issued) begin
         // Hold the beat until it is taken.
      end else if (req_wait > 0) begin
         req_valid <= 1'b0;
         req_wait  <= req_wait - 1;
      end else if (pending_reqs.size() > 0) begin
         req_data  <= pending_reqs.pop_front();
         req_valid <= 1'b1;
         beats_issued++;
         req_wait  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Response monitor: checks each beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response beat with nothing expected", '0, '0);
         end else begin
            mau_pkg::rsp_payload_type want;
            want = expected_rsps.pop_front();
            if (rsp_data.result_low !== want.result_low)
               report_mismatch("result_low", rsp_data.result_low, want.result_low);
            if (rsp_data.result_high !== want.result_high)
               report_mismatch("result_high", rsp_data.result_high, want.result_high);
            if (rsp_data.remainder_out !== want.remainder_out)
               report_mismatch("remainder_out", rsp_data.remainder_out, want.remainder_out);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
         end
         beats_checked++;
      end
   end

   // Receiver: stalls for a random number of cycles after each beat it takes.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
         rsp_seen  <= beats_checked;
      end else if (beats_checked != rsp_seen) begin
         rsp_seen <= beats_checked;
         rsp_gap  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait  <= rsp_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end else if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Wait at a falling edge until every queued beat has been answered.
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (PIPE_CYCLES) @(negedge clock);
   endtask

   task automatic write_modulus(logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      modulus_now      <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Stimulus: directed corners, then random phases under several moduli.
   initial begin
      logic [63:0] moduli[7];
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      modulus_now      = 64'd1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset modulus of one, then a large one.
      pending_reqs.push_back(make_req(mau_pkg::OP_ADD_MOD, '1, '1, 0, 0, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_NEGATE_MOD, 5, 0, 0, 0, 1));
      drain();
      write_modulus('1 - 64'd58);
      pending_reqs.push_back(make_req(mau_pkg::OP_ADD_MOD, '1, '1, 0, 0, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_WIDE_MUL, '1, '1, 0, 0, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_WIDE_MUL, 0, '1, 0, 0, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_MUL_MOD, '1, '1, 0, 0, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_DIVIDE, 0, 0, '1 - 1, '1, '1));
      pending_reqs.push_back(make_req(mau_pkg::OP_DIVIDE, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_req(mau_pkg::OP_DIVIDE, 0, 0, 7, 3, 7));
      pending_reqs.push_back(make_req(mau_pkg::OP_DIVIDE, 0, 0, 0, '1, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_DIVIDE_MOD, 0, 0, 0, '1, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_DIVIDE_MOD, 0, 0, 5, 9, 0));
      pending_reqs.push_back(make_req(mau_pkg::OP_DIVIDE_MOD, 0, 0, 9, 9, 3));
      pending_reqs.push_back(make_req(mau_pkg::OP_NEGATE_MOD, '1 - 64'd58, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_NEGATE_MOD, 0, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(mau_pkg::OP_NEGATE_MOD, '1, 0, 0, 0, 1));
      pending_reqs.push_back(make_req(3'd6, '1, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(3'd7, '1, '1, '1, '1, '1));
      drain();
      // A zero modulus makes every modular operation fail.
      write_modulus('0);
      for (int op = 0; op < 6; op++)
         pending_reqs.push_back(make_req(3'(op), 9, 4, 1, 2, 3));
      drain();

      // Random phases, one per modulus setting.
      moduli = '{64'd1, '1, 64'd2, 64'd1000003, 64'h8000_0000_0000_0001, 64'd0, 64'd97};
      foreach (moduli[i]) begin
         logic [63:0] md;
         md = (i == 3) ? (64'({$urandom, $urandom}) | 64'd1) : moduli[i];
         write_modulus(md);
         for (int n = 0; n < 285; n++) pending_reqs.push_back(rand_req());
         drain();
      end

      $display("Covered %0d request beats and %0d checked responses over several moduli,",
               beats_sent, beats_checked);
      $display("including zero, one, two and the largest modulus.");
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20000000;
      $display("Timeout with %0d responses outstanding", expected_rsps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
